@@ design/a51_pkg.sv @@
// ----------------------------------------------------------------------------
// a51_pkg
// Shared constants, types, microcode program and register step functions for
// the A5/1 keystream generator.
// ----------------------------------------------------------------------------
`default_nettype none

package a51_pkg;

	// Register and field widths
	localparam int R1_W        = 19;
	localparam int R2_W        = 22;
	localparam int R3_W        = 23;
	localparam int KEY_W       = 64;
	localparam int FRAME_W     = 22;
	localparam int REQ_W       = 2;
	localparam int BYTE_IDX_W  = 4;

	// Sequence lengths
	localparam int BURST_BITS_DEF = 114;
	localparam int KEY_STEPS      = 64;
	localparam int FRAME_STEPS    = 22;
	localparam int MIX_STEPS      = 100;
	localparam int MAX_BYTES      = 15;

	// Program counter width
	localparam int PC_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_SETUP  = 2'd0,
		REQ_DOUBLE = 2'd1,
		REQ_SINGLE = 2'd2,
		REQ_LOAD   = 2'd3
	} req_t;

	// Datapath operation of one microcode step
	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_CLEAR = 3'd1,
		OP_KEY   = 3'd2,
		OP_FRAME = 3'd3,
		OP_MIX   = 3'd4,
		OP_OUT0  = 3'd5,
		OP_OUT1  = 3'd6,
		OP_LOAD  = 3'd7
	} op_t;

	// Repeat count of one microcode step
	typedef enum logic [2:0] {
		LEN_ONE   = 3'd0,
		LEN_KEY   = 3'd1,
		LEN_FRAME = 3'd2,
		LEN_MIX   = 3'd3,
		LEN_BURST = 3'd4
	} len_t;

	// Where to go once a step has run its count
	typedef enum logic [1:0] {
		NX_NEXT       = 2'd0,
		NX_END        = 2'd1,
		NX_END_SINGLE = 2'd2
	} nx_t;

	typedef struct packed {
		op_t  op;
		len_t len;
		nx_t  nx;
	} ucode_t;

	// Program entry points
	localparam logic [PC_W-1:0] PC_SETUP = 3'd0;
	localparam logic [PC_W-1:0] PC_BURST = 3'd4;
	localparam logic [PC_W-1:0] PC_LOAD  = 3'd6;

	// Microcode program
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			3'd0:    w = '{op: OP_CLEAR, len: LEN_ONE,   nx: NX_NEXT};
			3'd1:    w = '{op: OP_KEY,   len: LEN_KEY,   nx: NX_NEXT};
			3'd2:    w = '{op: OP_FRAME, len: LEN_FRAME, nx: NX_NEXT};
			3'd3:    w = '{op: OP_MIX,   len: LEN_MIX,   nx: NX_END};
			3'd4:    w = '{op: OP_OUT0,  len: LEN_BURST, nx: NX_END_SINGLE};
			3'd5:    w = '{op: OP_OUT1,  len: LEN_BURST, nx: NX_END};
			3'd6:    w = '{op: OP_LOAD,  len: LEN_ONE,   nx: NX_END};
			default: w = '{op: OP_NOP,   len: LEN_ONE,   nx: NX_END};
		endcase
		return w;
	endfunction

	// Program entry for a request kind
	function automatic logic [PC_W-1:0] entry_pc(input req_t req);
		logic [PC_W-1:0] pc;
		unique case (req)
			REQ_SETUP:  pc = PC_SETUP;
			REQ_DOUBLE: pc = PC_BURST;
			REQ_SINGLE: pc = PC_BURST;
			default:    pc = PC_LOAD;
		endcase
		return pc;
	endfunction

	// Shift each register toward its MSB, feedback plus injected bit into bit 0
	function automatic logic [R1_W-1:0] r1_step(input logic [R1_W-1:0] r, input logic b);
		return {r[R1_W-2:0], r[18] ^ r[17] ^ r[16] ^ r[13] ^ b};
	endfunction

	function automatic logic [R2_W-1:0] r2_step(input logic [R2_W-1:0] r, input logic b);
		return {r[R2_W-2:0], r[21] ^ r[20] ^ b};
	endfunction

	function automatic logic [R3_W-1:0] r3_step(input logic [R3_W-1:0] r, input logic b);
		return {r[R3_W-2:0], r[22] ^ r[21] ^ r[20] ^ r[7] ^ b};
	endfunction

endpackage

`default_nettype wire

@@ design/a51_req_if.sv @@
// ----------------------------------------------------------------------------
// a51_req_if
// Request channel: request kind, frame number and register load values.
// ----------------------------------------------------------------------------
`default_nettype none

interface a51_req_if;

	logic                        valid;
	logic                        ready;
	logic [a51_pkg::REQ_W-1:0]   req_type;
	logic [a51_pkg::FRAME_W-1:0] frame_number;
	logic [a51_pkg::R1_W-1:0]    load_r1;
	logic [a51_pkg::R2_W-1:0]    load_r2;
	logic [a51_pkg::R3_W-1:0]    load_r3;

	modport source (
		output valid, req_type, frame_number, load_r1, load_r2, load_r3,
		input  ready
	);

	modport sink (
		input  valid, req_type, frame_number, load_r1, load_r2, load_r3,
		output ready
	);

endinterface

`default_nettype wire

@@ design/a51_ks_if.sv @@
// ----------------------------------------------------------------------------
// a51_ks_if
// Keystream channel: one packed keystream byte per transfer with its tags.
// ----------------------------------------------------------------------------
`default_nettype none

interface a51_ks_if;

	logic                           valid;
	logic                           ready;
	logic [7:0]                     keystream_byte;
	logic                           burst_dir;
	logic [a51_pkg::BYTE_IDX_W-1:0] byte_index;
	logic                           last;

	modport source (
		output valid, keystream_byte, burst_dir, byte_index, last,
		input  ready
	);

	modport sink (
		input  valid, keystream_byte, burst_dir, byte_index, last,
		output ready
	);

endinterface

`default_nettype wire

@@ design/a51_keystream_generator_unit.sv @@
// ----------------------------------------------------------------------------
// a51_keystream_generator_unit
// A5/1 keystream generator run by a small microcode sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   key_we/key_wdata load the 64-bit session key; write it only while idle.
//   req (valid/ready) takes one request: setup, double burst, single burst or
//   register load. req.ready is high whenever the sequencer is idle.
//   ks (valid/ready) returns keystream bytes, earliest bit in the MSB, tagged
//   with burst_dir, byte_index and last on the final byte of the request.
// Steps (one microcode step and one register clock per cycle, unless stalled):
//   setup        clear, 64 key, 22 frame and 100 mixing steps, no output
//   single burst BURST_BITS steps, a byte per 8 bits, the last may be partial
//   double burst two bursts of BURST_BITS steps each
//   load         a single step
//   The next request can be taken as soon as the sequencer is idle again.
//   A byte enters the output register with the step that clocks its last bit.
// Reset clears the three registers and the key, and empties the output.
// While the receiver stalls, the last byte waits in the output register and
// the sequencer holds on the step that would complete the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module a51_keystream_generator_unit #(
	parameter int BURST_BITS = a51_pkg::BURST_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       key_we,
	input  wire logic [a51_pkg::KEY_W-1:0]  key_wdata,
	a51_req_if.sink                         req,
	a51_ks_if.source                        ks
);

	localparam int LOOP_MAX = (BURST_BITS > a51_pkg::MIX_STEPS) ?
	                          BURST_BITS : a51_pkg::MIX_STEPS;
	localparam int CNT_W    = $clog2(LOOP_MAX);
	localparam int KEEP_BITS = (BURST_BITS > a51_pkg::MAX_BYTES * 8) ?
	                          a51_pkg::MAX_BYTES * 8 : BURST_BITS;
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(KEEP_BITS - 1);

	// Sequencer state
	logic                         busy_q;
	logic [a51_pkg::PC_W-1:0]     pc_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         single_q;

	// Datapath state
	logic [a51_pkg::KEY_W-1:0]    key_q;
	logic [a51_pkg::R1_W-1:0]     r1_q;
	logic [a51_pkg::R2_W-1:0]     r2_q;
	logic [a51_pkg::R3_W-1:0]     r3_q;
	logic [a51_pkg::FRAME_W-1:0]  frame_q;
	logic [a51_pkg::R1_W-1:0]     ld1_q;
	logic [a51_pkg::R2_W-1:0]     ld2_q;
	logic [a51_pkg::R3_W-1:0]     ld3_q;
	logic [7:0]                   byte_q;

	// Output register
	logic                         ks_valid_q;
	logic [7:0]                   ks_byte_q;
	logic                         ks_dir_q;
	logic [a51_pkg::BYTE_IDX_W-1:0] ks_idx_q;
	logic                         ks_last_q;

	a51_pkg::ucode_t              ctrl;
	logic [CNT_W-1:0]             loop_last;
	logic                         is_out;
	logic                         c1, c2, c3, maj;
	logic [a51_pkg::R1_W-1:0]     r1_m;
	logic [a51_pkg::R2_W-1:0]     r2_m;
	logic [a51_pkg::R3_W-1:0]     r3_m;
	logic                         out_bit;
	logic                         keep_pos;
	logic                         emit_pos;
	logic                         slot_free;
	logic                         step_en;
	logic                         emit;
	logic                         loop_done;
	logic                         finish;
	logic [7:0]                   byte_next;
	logic                         accept;
	logic                         key_bit;

	// Decode the current control word and its repeat count
	always_comb begin
		ctrl = a51_pkg::ucode_rom(pc_q);
		unique case (ctrl.len)
			a51_pkg::LEN_ONE:   loop_last = '0;
			a51_pkg::LEN_KEY:   loop_last = CNT_W'(a51_pkg::KEY_STEPS - 1);
			a51_pkg::LEN_FRAME: loop_last = CNT_W'(a51_pkg::FRAME_STEPS - 1);
			a51_pkg::LEN_MIX:   loop_last = CNT_W'(a51_pkg::MIX_STEPS - 1);
			a51_pkg::LEN_BURST: loop_last = CNT_W'(BURST_BITS - 1);
			default:            loop_last = '0;
		endcase
		is_out = (ctrl.op == a51_pkg::OP_OUT0) || (ctrl.op == a51_pkg::OP_OUT1);
	end

	// Majority clocking and keystream bit
	always_comb begin
		c1      = r1_q[8];
		c2      = r2_q[10];
		c3      = r3_q[10];
		maj     = (c1 & c2) | (c1 & c3) | (c2 & c3);
		r1_m    = (c1 == maj) ? a51_pkg::r1_step(r1_q, 1'b0) : r1_q;
		r2_m    = (c2 == maj) ? a51_pkg::r2_step(r2_q, 1'b0) : r2_q;
		r3_m    = (c3 == maj) ? a51_pkg::r3_step(r3_q, 1'b0) : r3_q;
		out_bit = r1_m[a51_pkg::R1_W-1] ^ r2_m[a51_pkg::R2_W-1] ^ r3_m[a51_pkg::R3_W-1];
		key_bit = key_q[cnt_q[5:0]];
	end

	// Byte packing, output slot and loop control
	always_comb begin
		keep_pos  = cnt_q <= LAST_BIT;
		emit_pos  = keep_pos && ((cnt_q[2:0] == 3'b111) || (cnt_q == LAST_BIT));
		slot_free = !ks_valid_q || ks.ready;
		step_en   = busy_q && !(is_out && emit_pos && !slot_free);
		emit      = step_en && is_out && emit_pos;
		loop_done = cnt_q == loop_last;
		finish    = loop_done && ((ctrl.nx == a51_pkg::NX_END) ||
		            ((ctrl.nx == a51_pkg::NX_END_SINGLE) && single_q));
		byte_next = byte_q | (8'(out_bit) << (3'd7 - cnt_q[2:0]));
		accept    = req.valid && !busy_q;
	end

	assign req.ready         = !busy_q;
	assign ks.valid          = ks_valid_q;
	assign ks.keystream_byte = ks_byte_q;
	assign ks.burst_dir      = ks_dir_q;
	assign ks.byte_index     = ks_idx_q;
	assign ks.last           = ks_last_q;

	// Session key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_we) begin
			key_q <= key_wdata;
		end
	end

	// Step counter and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pc_q     <= '0;
			cnt_q    <= '0;
			single_q <= 1'b0;
		end else if (accept) begin
			busy_q   <= 1'b1;
			pc_q     <= a51_pkg::entry_pc(a51_pkg::req_t'(req.req_type));
			cnt_q    <= '0;
			single_q <= req.req_type == a51_pkg::REQ_SINGLE;
		end else if (step_en) begin
			if (loop_done) begin
				cnt_q <= '0;
				if (finish) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Shift registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
		end else if (step_en) begin
			unique case (ctrl.op)
				a51_pkg::OP_CLEAR: begin
					r1_q <= '0;
					r2_q <= '0;
					r3_q <= '0;
				end
				a51_pkg::OP_KEY: begin
					r1_q <= a51_pkg::r1_step(r1_q, key_bit);
					r2_q <= a51_pkg::r2_step(r2_q, key_bit);
					r3_q <= a51_pkg::r3_step(r3_q, key_bit);
				end
				a51_pkg::OP_FRAME: begin
					r1_q <= a51_pkg::r1_step(r1_q, frame_q[0]);
					r2_q <= a51_pkg::r2_step(r2_q, frame_q[0]);
					r3_q <= a51_pkg::r3_step(r3_q, frame_q[0]);
				end
				a51_pkg::OP_MIX, a51_pkg::OP_OUT0, a51_pkg::OP_OUT1: begin
					r1_q <= r1_m;
					r2_q <= r2_m;
					r3_q <= r3_m;
				end
				a51_pkg::OP_LOAD: begin
					r1_q <= ld1_q;
					r2_q <= ld2_q;
					r3_q <= ld3_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Operand latches: capture at transfer, shift frame bits LSB first
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= req.frame_number;
			ld1_q   <= req.load_r1;
			ld2_q   <= req.load_r2;
			ld3_q   <= req.load_r3;
		end else if (step_en && (ctrl.op == a51_pkg::OP_FRAME)) begin
			frame_q <= frame_q >> 1;
		end
	end

	// Byte assembly: clear at transfer and after each emitted byte
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= '0;
		end else if (step_en && is_out && keep_pos) begin
			byte_q <= emit_pos ? 8'd0 : byte_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_valid_q <= 1'b0;
		end else if (emit) begin
			ks_valid_q <= 1'b1;
		end else if (ks.ready) begin
			ks_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ks_byte_q <= byte_next;
			ks_dir_q  <= ctrl.op == a51_pkg::OP_OUT1;
			ks_idx_q  <= cnt_q[6:3];
			ks_last_q <= (cnt_q == LAST_BIT) &&
			             ((ctrl.op == a51_pkg::OP_OUT1) || single_q);
		end
	end

`ifndef SYNTH
	// A byte is produced only by a burst step
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (busy_q && is_out))
		else $error("keystream byte emitted outside a burst step");

	// The step counter never runs past the current step's count
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= loop_last))
		else $error("step counter beyond loop length");

	// A taken request makes the sequencer busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> busy_q)
		else $error("request taken but sequencer not started");

	// An unsent byte is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(ks_valid_q && !ks.ready) |-> !emit)
		else $error("output byte overwritten while stalled");
`endif

endmodule

`default_nettype wire
